// ----- rtl/core/dlc_pkg.sv -----
// ----------------------------------------------------------------------------
// dlc_pkg
// Shared types and constants for the depth compositing block.
// ----------------------------------------------------------------------------
`default_nettype none
package dlc_pkg;
  localparam int unsigned DEPTH_W = 32;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR = 2'd0,
    CFG_FAR  = 2'd1,
    CFG_WIDE = 2'd2
  } cfg_reg_t;

  localparam logic [31:0] NEAR_RST = 32'd65536;
  localparam logic [31:0] FAR_RST  = 32'd6553600;
  localparam logic [31:0] SAT_MAX  = 32'hFFFF_FFFF;
endpackage
`default_nettype wire

// ----- rtl/core/dlc_div.sv -----
// ----------------------------------------------------------------------------
// dlc_div
// Pipelined eye-depth converter: products, then restoring division at one
// quotient bit per stage, saturating on overflow or a zero divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module dlc_div
  import dlc_pkg::*;
#(
  parameter int TAG_W = 57
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire logic [TAG_W-1:0]  in_tag,
  input  wire logic [31:0]       in_raw,
  input  wire logic              in_wide,
  input  wire logic [31:0]       in_near,
  input  wire logic [31:0]       in_far,
  output logic                   out_vld,
  output logic [TAG_W-1:0]       out_tag,
  output logic [31:0]            out_z
);
  localparam int NS = 32;

  // stage A: masked raw, m - r, n*f
  logic              a_vld_r;
  logic [TAG_W-1:0]  a_tag_r;
  logic [31:0]       a_r_r, a_mr_r, a_n_r, a_f_r;
  logic              a_wide_r;
  logic [63:0]       a_nf_r;
  // stage B: products
  logic              b_vld_r;
  logic [TAG_W-1:0]  b_tag_r;
  logic [63:0]       b_fm_r, b_nr_r, b_nf_r;
  logic              b_wide_r;
  // stage C: denominator, numerator
  logic              c_vld_r;
  logic [TAG_W-1:0]  c_tag_r;
  logic [64:0]       c_den_r;
  logic [95:0]       c_num_r;
  // stage D: saturation check
  logic              d_vld_r;
  logic [TAG_W-1:0]  d_tag_r;
  logic [63:0]       d_den_r;
  logic [63:0]       d_rem_r;
  logic [31:0]       d_low_r;
  logic              d_sat_r;

  logic [31:0] raw_m, mr_m;
  always_comb begin
    raw_m = in_wide ? in_raw : {16'd0, in_raw[15:0]};
    mr_m  = in_wide ? ~in_raw : {16'd0, ~in_raw[15:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
    a_tag_r  <= in_tag;
    a_r_r    <= raw_m;
    a_mr_r   <= mr_m;
    a_n_r    <= in_near;
    a_f_r    <= in_far;
    a_wide_r <= in_wide;
    a_nf_r   <= 64'(in_near) * 64'(in_far);
    b_tag_r  <= a_tag_r;
    b_fm_r   <= 64'(a_f_r) * 64'(a_mr_r);
    b_nr_r   <= 64'(a_n_r) * 64'(a_r_r);
    b_nf_r   <= a_nf_r;
    b_wide_r <= a_wide_r;
    c_tag_r  <= b_tag_r;
    c_den_r  <= 65'(b_fm_r) + 65'(b_nr_r);
    // nf * m with m = 2^k - 1
    c_num_r  <= b_wide_r ? ({b_nf_r, 32'd0} - 96'(b_nf_r))
                         : ({16'd0, b_nf_r, 16'd0} - 96'(b_nf_r));
    d_tag_r  <= c_tag_r;
    d_den_r  <= c_den_r[63:0];
    d_rem_r  <= c_num_r[95:32];
    d_low_r  <= c_num_r[31:0];
    d_sat_r  <= (c_den_r == 65'd0) || (65'(c_num_r[95:32]) >= c_den_r);
  end

  // one quotient bit per stage
  logic              s_vld_r [NS+1];
  logic [TAG_W-1:0]  s_tag_r [NS+1];
  logic [63:0]       s_den_r [NS+1];
  logic [63:0]       s_rem_r [NS+1];
  logic [31:0]       s_low_r [NS+1];
  logic [31:0]       s_q_r   [NS+1];
  logic              s_sat_r [NS+1];

  always_comb begin
    s_vld_r[0] = d_vld_r;
    s_tag_r[0] = d_tag_r;
    s_den_r[0] = d_den_r;
    s_rem_r[0] = d_rem_r;
    s_low_r[0] = d_low_r;
    s_q_r[0]   = 32'd0;
    s_sat_r[0] = d_sat_r;
  end

  for (genvar g = 0; g < NS; g++) begin : g_step
    logic [64:0] sh;
    logic        take;
    assign sh   = {s_rem_r[g], s_low_r[g][31]};
    assign take = sh >= 65'(s_den_r[g]);
    always_ff @(posedge clk) begin
      if (!rst_n) s_vld_r[g+1] <= 1'b0;
      else        s_vld_r[g+1] <= s_vld_r[g];
      s_tag_r[g+1] <= s_tag_r[g];
      s_den_r[g+1] <= s_den_r[g];
      s_rem_r[g+1] <= take ? 64'(sh - 65'(s_den_r[g])) : sh[63:0];
      s_low_r[g+1] <= {s_low_r[g][30:0], 1'b0};
      s_q_r[g+1]   <= {s_q_r[g][30:0], take};
      s_sat_r[g+1] <= s_sat_r[g];
    end
  end

  assign out_vld = s_vld_r[NS];
  assign out_tag = s_tag_r[NS];
  assign out_z   = s_sat_r[NS] ? SAT_MAX : s_q_r[NS];
endmodule
`default_nettype wire

// ----- rtl/core/depth_linearize_composite.sv -----
// ----------------------------------------------------------------------------
// depth_linearize_composite
// Z-buffer compositing of fragments with window-to-eye depth conversion.
// ----------------------------------------------------------------------------
//  channel | ports                         | handshake
//  input   | in_* fields, start            | start & !busy
//  result  | out_* fields                  | out_strobe, one cycle
//  config  | cfg_we, cfg_index, cfg_data   | cfg_we
//
//  One pixel per clock; busy is always low. A result passes through four
//  stages for the products and the saturation check, 32 restoring division
//  steps, a memory read with the compare, and the output register.
//  Read-after-write on the same pixel is forwarded from the two most recent
//  writes. Stores have no reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module depth_linearize_composite
  import dlc_pkg::*;
#(
  parameter int FRAME_PIXELS = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_pixel_index,
  input  wire logic [7:0]  in_red_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_blue_in,
  input  wire logic [31:0] in_raw_depth,
  input  wire logic        in_first_pass,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             out_strobe,
  output logic [15:0]      out_pixel_out_index,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic [31:0]      out_eye_depth,
  output logic             out_replaced
);
  localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int TAG_W = 16 + 16 + COLOR_W + 1;
  localparam logic [24:0] FRAME_W = 25'(FRAME_PIXELS);
  // ceil(2^32 / FRAME_PIXELS): exact quotient for any 16-bit index
  localparam logic [31:0] SLOT_RECIP =
    32'(((64'd1 << 32) + 64'(FRAME_PIXELS) - 64'd1) / 64'(FRAME_PIXELS));

  logic [31:0] near_r, far_r;
  logic        wide_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= NEAR_RST;
      far_r  <= FAR_RST;
      wide_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_NEAR: near_r <= cfg_data;
        CFG_FAR:  far_r  <= cfg_data;
        CFG_WIDE: wide_r <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  assign busy = 1'b0;

  // frame quotient of the index, carried with the beat
  logic [47:0]       in_prod;
  logic [15:0]       in_quot;
  assign in_prod = 48'(in_pixel_index) * 48'(SLOT_RECIP);
  assign in_quot = in_prod[47:32];

  logic              dv_vld;
  logic [TAG_W-1:0]  dv_tag;
  logic [31:0]       dv_z;

  dlc_div #(.TAG_W(TAG_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .in_tag  ({in_pixel_index, in_quot, in_red_in, in_green_in, in_blue_in,
               in_first_pass}),
    .in_raw  (in_raw_depth),
    .in_wide (wide_r),
    .in_near (near_r),
    .in_far  (far_r),
    .out_vld (dv_vld),
    .out_tag (dv_tag),
    .out_z   (dv_z)
  );

  function automatic logic [AW-1:0] slot_of(input logic [15:0] pix,
                                            input logic [15:0] quot);
    logic [40:0] rem;
    rem = 41'(pix) - 41'(quot) * 41'(FRAME_W);
    return rem[AW-1:0];
  endfunction

  // memory: color and depth per pixel
  logic [COLOR_W+DEPTH_W-1:0] mem [FRAME_PIXELS];
  logic [COLOR_W+DEPTH_W-1:0] rd_data_r;

  // read stage
  logic              r_vld_r;
  logic [TAG_W-1:0]  r_tag_r;
  logic [31:0]       r_z_r;
  logic [AW-1:0]     r_slot_r;
  logic [AW-1:0]     dv_slot;

  // write-back stage
  logic              w_vld_r;
  logic [AW-1:0]     w_slot_r;
  logic [COLOR_W+DEPTH_W-1:0] w_data_r;
  // older write, still visible for a read issued alongside it
  logic              w2_vld_r;
  logic [AW-1:0]     w2_slot_r;
  logic [COLOR_W+DEPTH_W-1:0] w2_data_r;

  assign dv_slot = slot_of(dv_tag[TAG_W-1 -: 16], dv_tag[TAG_W-17 -: 16]);

  logic [COLOR_W+DEPTH_W-1:0] cur, new_ent, res_ent;
  logic                       wr;

  always_comb begin
    cur = rd_data_r;
    if (w2_vld_r && w2_slot_r == r_slot_r) cur = w2_data_r;
    if (w_vld_r && w_slot_r == r_slot_r)   cur = w_data_r;
    new_ent = {r_tag_r[COLOR_W:1], r_z_r};
    wr      = r_tag_r[0] || (r_z_r < cur[DEPTH_W-1:0]);
    res_ent = wr ? new_ent : cur;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[dv_slot];
    if (r_vld_r && wr) mem[r_slot_r] <= new_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r    <= 1'b0;
      w_vld_r    <= 1'b0;
      w2_vld_r   <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      r_vld_r    <= dv_vld;
      // hold the entry as now stored so the next read sees it
      w_vld_r    <= r_vld_r;
      w2_vld_r   <= w_vld_r;
      out_strobe <= r_vld_r;
    end
    r_tag_r   <= dv_tag;
    r_z_r     <= dv_z;
    r_slot_r  <= dv_slot;
    w_slot_r  <= r_slot_r;
    w_data_r  <= res_ent;
    w2_slot_r <= w_slot_r;
    w2_data_r <= w_data_r;
    out_pixel_out_index <= r_tag_r[TAG_W-1 -: 16];
    out_red_out   <= res_ent[55:48];
    out_green_out <= res_ent[47:40];
    out_blue_out  <= res_ent[39:32];
    out_eye_depth <= res_ent[31:0];
    out_replaced  <= wr;
  end

  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_first_writes: assert property (@(posedge clk) disable iff (!rst_n)
    r_vld_r && r_tag_r[0] |=> out_replaced)
    else $error("first pass not written");
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    r_vld_r |=> out_strobe)
    else $error("result lost");
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe during reset");
endmodule
`default_nettype wire
